FILE: sv/archive_record_parser_pearson_defines.svh
// Assertion macros for the record parser checker
`ifndef ARCHIVE_RECORD_PARSER_PEARSON_DEFINES_SVH
`define ARCHIVE_RECORD_PARSER_PEARSON_DEFINES_SVH
// assert that ante implies cons in the next cycle
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// assert that ante implies cons in the same cycle
`define ARP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

FILE: sv/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Types, codes and the Pearson permutation for the archive record parser.
// ----------------------------------------------------------------------------
package arp_pkg;
	localparam logic [7:0] MAGIC = 8'h42;

	typedef enum logic [2:0] {
		PH_IDLE, PH_MODE, PH_NAMELEN, PH_CONTLEN, PH_NAME, PH_CONTENT, PH_CHECK
	} phase_t;

	typedef enum logic [2:0] {
		K_HEADER = 3'd0, K_NAME = 3'd1, K_CONTENT = 3'd2,
		K_OK = 3'd3, K_ERROR = 3'd4, K_DONE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE = 3'd0, E_MAGIC = 3'd1, E_TR_MODE = 3'd2, E_TR_NAMELEN = 3'd3,
		E_TR_CONTLEN = 3'd4, E_TR_NAME = 3'd5, E_CHK_MISSING = 3'd6, E_CHK_WRONG = 3'd7
	} err_t;

	// one classified request handed from the front to the back part
	typedef struct packed {
		kind_t       kind;
		logic [23:0] mode_val;
		logic [15:0] name_length;
		logic [47:0] body_len;
		logic [7:0]  out_byte;
		err_t        error_code;
		logic [7:0]  hash_value;
	} result_t;

	function automatic logic [7:0] perm(input logic [7:0] i);
		logic [7:0] r;
		case (i)
		8'd0: r=8'd241; 8'd1: r=8'd18; 8'd2: r=8'd181; 8'd3: r=8'd164; 8'd4: r=8'd92;
		8'd5: r=8'd237; 8'd6: r=8'd100; 8'd7: r=8'd216; 8'd8: r=8'd183; 8'd9: r=8'd107;
		8'd10: r=8'd2; 8'd11: r=8'd12; 8'd12: r=8'd43; 8'd13: r=8'd246; 8'd14: r=8'd90;
		8'd15: r=8'd143; 8'd16: r=8'd251; 8'd17: r=8'd49; 8'd18: r=8'd228; 8'd19: r=8'd134;
		8'd20: r=8'd215; 8'd21: r=8'd20; 8'd22: r=8'd193; 8'd23: r=8'd172; 8'd24: r=8'd140;
		8'd25: r=8'd227; 8'd26: r=8'd148; 8'd27: r=8'd118; 8'd28: r=8'd57; 8'd29: r=8'd72;
		8'd30: r=8'd119; 8'd31: r=8'd174; 8'd32: r=8'd78; 8'd33: r=8'd14; 8'd34: r=8'd97;
		8'd35: r=8'd3; 8'd36: r=8'd208; 8'd37: r=8'd252; 8'd38: r=8'd11; 8'd39: r=8'd195;
		8'd40: r=8'd31; 8'd41: r=8'd28; 8'd42: r=8'd121; 8'd43: r=8'd206; 8'd44: r=8'd149;
		8'd45: r=8'd23; 8'd46: r=8'd83; 8'd47: r=8'd154; 8'd48: r=8'd223; 8'd49: r=8'd109;
		8'd50: r=8'd89; 8'd51: r=8'd10; 8'd52: r=8'd178; 8'd53: r=8'd243; 8'd54: r=8'd42;
		8'd55: r=8'd194; 8'd56: r=8'd221; 8'd57: r=8'd131; 8'd58: r=8'd212; 8'd59: r=8'd94;
		8'd60: r=8'd205; 8'd61: r=8'd240; 8'd62: r=8'd161; 8'd63: r=8'd7; 8'd64: r=8'd62;
		8'd65: r=8'd214; 8'd66: r=8'd222; 8'd67: r=8'd219; 8'd68: r=8'd1; 8'd69: r=8'd84;
		8'd70: r=8'd95; 8'd71: r=8'd58; 8'd72: r=8'd103; 8'd73: r=8'd60; 8'd74: r=8'd33;
		8'd75: r=8'd111; 8'd76: r=8'd188; 8'd77: r=8'd218; 8'd78: r=8'd186; 8'd79: r=8'd166;
		8'd80: r=8'd146; 8'd81: r=8'd189; 8'd82: r=8'd201; 8'd83: r=8'd155; 8'd84: r=8'd68;
		8'd85: r=8'd145; 8'd86: r=8'd44; 8'd87: r=8'd163; 8'd88: r=8'd69; 8'd89: r=8'd196;
		8'd90: r=8'd115; 8'd91: r=8'd231; 8'd92: r=8'd61; 8'd93: r=8'd157; 8'd94: r=8'd165;
		8'd95: r=8'd213; 8'd96: r=8'd139; 8'd97: r=8'd112; 8'd98: r=8'd173; 8'd99: r=8'd191;
		8'd100: r=8'd142; 8'd101: r=8'd88; 8'd102: r=8'd106; 8'd103: r=8'd250; 8'd104: r=8'd8;
		8'd105: r=8'd127; 8'd106: r=8'd26; 8'd107: r=8'd126; 8'd108: r=8'd0; 8'd109: r=8'd96;
		8'd110: r=8'd52; 8'd111: r=8'd182; 8'd112: r=8'd113; 8'd113: r=8'd38; 8'd114: r=8'd242;
		8'd115: r=8'd48; 8'd116: r=8'd204; 8'd117: r=8'd160; 8'd118: r=8'd15; 8'd119: r=8'd54;
		8'd120: r=8'd158; 8'd121: r=8'd192; 8'd122: r=8'd81; 8'd123: r=8'd125; 8'd124: r=8'd245;
		8'd125: r=8'd239; 8'd126: r=8'd101; 8'd127: r=8'd17; 8'd128: r=8'd136; 8'd129: r=8'd110;
		8'd130: r=8'd24; 8'd131: r=8'd53; 8'd132: r=8'd132; 8'd133: r=8'd117; 8'd134: r=8'd102;
		8'd135: r=8'd153; 8'd136: r=8'd226; 8'd137: r=8'd4; 8'd138: r=8'd203; 8'd139: r=8'd199;
		8'd140: r=8'd16; 8'd141: r=8'd249; 8'd142: r=8'd211; 8'd143: r=8'd167; 8'd144: r=8'd55;
		8'd145: r=8'd255; 8'd146: r=8'd254; 8'd147: r=8'd116; 8'd148: r=8'd122; 8'd149: r=8'd13;
		8'd150: r=8'd236; 8'd151: r=8'd93; 8'd152: r=8'd144; 8'd153: r=8'd86; 8'd154: r=8'd59;
		8'd155: r=8'd76; 8'd156: r=8'd150; 8'd157: r=8'd162; 8'd158: r=8'd207; 8'd159: r=8'd77;
		8'd160: r=8'd176; 8'd161: r=8'd32; 8'd162: r=8'd124; 8'd163: r=8'd171; 8'd164: r=8'd29;
		8'd165: r=8'd45; 8'd166: r=8'd30; 8'd167: r=8'd67; 8'd168: r=8'd184; 8'd169: r=8'd51;
		8'd170: r=8'd22; 8'd171: r=8'd105; 8'd172: r=8'd170; 8'd173: r=8'd253; 8'd174: r=8'd180;
		8'd175: r=8'd187; 8'd176: r=8'd130; 8'd177: r=8'd156; 8'd178: r=8'd98; 8'd179: r=8'd159;
		8'd180: r=8'd220; 8'd181: r=8'd40; 8'd182: r=8'd133; 8'd183: r=8'd135; 8'd184: r=8'd114;
		8'd185: r=8'd147; 8'd186: r=8'd75; 8'd187: r=8'd73; 8'd188: r=8'd210; 8'd189: r=8'd21;
		8'd190: r=8'd129; 8'd191: r=8'd39; 8'd192: r=8'd138; 8'd193: r=8'd91; 8'd194: r=8'd41;
		8'd195: r=8'd235; 8'd196: r=8'd47; 8'd197: r=8'd185; 8'd198: r=8'd9; 8'd199: r=8'd82;
		8'd200: r=8'd64; 8'd201: r=8'd87; 8'd202: r=8'd244; 8'd203: r=8'd50; 8'd204: r=8'd74;
		8'd205: r=8'd233; 8'd206: r=8'd175; 8'd207: r=8'd247; 8'd208: r=8'd120; 8'd209: r=8'd6;
		8'd210: r=8'd169; 8'd211: r=8'd85; 8'd212: r=8'd66; 8'd213: r=8'd104; 8'd214: r=8'd80;
		8'd215: r=8'd71; 8'd216: r=8'd230; 8'd217: r=8'd152; 8'd218: r=8'd225; 8'd219: r=8'd34;
		8'd220: r=8'd248; 8'd221: r=8'd198; 8'd222: r=8'd63; 8'd223: r=8'd168; 8'd224: r=8'd179;
		8'd225: r=8'd141; 8'd226: r=8'd137; 8'd227: r=8'd5; 8'd228: r=8'd19; 8'd229: r=8'd79;
		8'd230: r=8'd232; 8'd231: r=8'd128; 8'd232: r=8'd202; 8'd233: r=8'd46; 8'd234: r=8'd70;
		8'd235: r=8'd37; 8'd236: r=8'd209; 8'd237: r=8'd217; 8'd238: r=8'd123; 8'd239: r=8'd27;
		8'd240: r=8'd177; 8'd241: r=8'd25; 8'd242: r=8'd56; 8'd243: r=8'd65; 8'd244: r=8'd229;
		8'd245: r=8'd36; 8'd246: r=8'd197; 8'd247: r=8'd234; 8'd248: r=8'd108; 8'd249: r=8'd35;
		8'd250: r=8'd151; 8'd251: r=8'd238; 8'd252: r=8'd200; 8'd253: r=8'd224; 8'd254: r=8'd99;
		default: r=8'd190;
		endcase
		return r;
	endfunction
endpackage

FILE: sv/arp_front.sv
// ----------------------------------------------------------------------------
// arp_front
// Parser state machine: hashes the record bytes and classifies them into results.
// ----------------------------------------------------------------------------
module arp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              verify_hash,
	input  logic              in_fire,
	input  logic [7:0]        data_byte,
	input  logic              stream_end,
	output logic              res_valid,
	output arp_pkg::result_t  res
);
	arp_pkg::phase_t phase_q, phase_d;
	logic [47:0] count_q, count_d;
	logic [7:0]  hash_q, hash_d;
	logic [23:0] mode_q, mode_d;
	logic [15:0] nlen_q, nlen_d;
	logic [47:0] clen_q, clen_d;
	logic        halted_q, halted_d;
	logic [7:0]  hnext;
	logic [47:0] count_inc;

	assign hnext     = arp_pkg::perm(hash_q ^ data_byte);
	assign count_inc = count_q + 48'd1;

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		hash_d   = hash_q;
		mode_d   = mode_q;
		nlen_d   = nlen_q;
		clen_d   = clen_q;
		halted_d = halted_q;
		res_valid = 1'b0;
		res.kind = arp_pkg::K_DONE;
		res.out_byte = 8'd0;
		res.error_code = arp_pkg::E_NONE;
		res.hash_value = hash_q;
		if (in_fire && !halted_q) begin
			if (stream_end) begin
				res_valid = 1'b1;
				res.kind = arp_pkg::K_ERROR;
				halted_d = 1'b1;
				case (phase_q)
				arp_pkg::PH_IDLE: begin
					res.kind = arp_pkg::K_DONE;
					res.hash_value = 8'd0;
					halted_d = 1'b0;
				end
				arp_pkg::PH_MODE:    res.error_code = arp_pkg::E_TR_MODE;
				arp_pkg::PH_NAMELEN: res.error_code = arp_pkg::E_TR_NAMELEN;
				arp_pkg::PH_CONTLEN: res.error_code = arp_pkg::E_TR_CONTLEN;
				arp_pkg::PH_NAME:    res.error_code = arp_pkg::E_TR_NAME;
				default: begin
					if (verify_hash) begin
						res.error_code = arp_pkg::E_CHK_MISSING;
					end else begin
						res.kind = arp_pkg::K_DONE;
						halted_d = 1'b0;
						phase_d = arp_pkg::PH_IDLE;
						count_d = 48'd0;
						hash_d = 8'd0;
					end
				end
				endcase
			end else begin
				hash_d = hnext;
				case (phase_q)
				arp_pkg::PH_IDLE: begin
					hash_d = arp_pkg::perm(data_byte);
					if (data_byte != arp_pkg::MAGIC) begin
						res_valid = 1'b1;
						res.kind = arp_pkg::K_ERROR;
						res.error_code = arp_pkg::E_MAGIC;
						res.hash_value = hash_d;
						halted_d = 1'b1;
					end else begin
						mode_d = 24'd0;
						nlen_d = 16'd0;
						clen_d = 48'd0;
						count_d = 48'd0;
						phase_d = arp_pkg::PH_MODE;
					end
				end
				arp_pkg::PH_MODE: begin
					mode_d = {mode_q[15:0], data_byte};
					count_d = count_inc;
					if (count_q[1:0] == 2'd2) begin
						count_d = 48'd0;
						phase_d = arp_pkg::PH_NAMELEN;
					end
				end
				arp_pkg::PH_NAMELEN: begin
					nlen_d = {nlen_q[7:0], data_byte};
					count_d = count_inc;
					if (count_q[1:0] == 2'd1) begin
						count_d = 48'd0;
						phase_d = arp_pkg::PH_CONTLEN;
					end
				end
				arp_pkg::PH_CONTLEN: begin
					clen_d = {clen_q[39:0], data_byte};
					count_d = count_inc;
					if (count_q[2:0] == 3'd5) begin
						res_valid = 1'b1;
						res.kind = arp_pkg::K_HEADER;
						res.hash_value = hnext;
						count_d = 48'd0;
						if (nlen_q != 16'd0)
							phase_d = arp_pkg::PH_NAME;
						else if (clen_d != 48'd0)
							phase_d = arp_pkg::PH_CONTENT;
						else
							phase_d = arp_pkg::PH_CHECK;
					end
				end
				arp_pkg::PH_NAME: begin
					res_valid = 1'b1;
					res.kind = arp_pkg::K_NAME;
					res.out_byte = data_byte;
					res.hash_value = hnext;
					count_d = count_inc;
					if (count_inc[15:0] >= nlen_q) begin
						count_d = 48'd0;
						phase_d = (clen_q != 48'd0) ? arp_pkg::PH_CONTENT : arp_pkg::PH_CHECK;
					end
				end
				arp_pkg::PH_CONTENT: begin
					res_valid = 1'b1;
					res.kind = arp_pkg::K_CONTENT;
					res.out_byte = data_byte;
					res.hash_value = hnext;
					count_d = count_inc;
					if (count_inc >= clen_q) begin
						count_d = 48'd0;
						phase_d = arp_pkg::PH_CHECK;
					end
				end
				default: begin
					hash_d = 8'd0;
					res_valid = 1'b1;
					if (verify_hash && data_byte != hash_q) begin
						res.kind = arp_pkg::K_ERROR;
						res.error_code = arp_pkg::E_CHK_WRONG;
						halted_d = 1'b1;
						hash_d = hash_q;
					end else begin
						res.kind = arp_pkg::K_OK;
						count_d = 48'd0;
						phase_d = arp_pkg::PH_IDLE;
					end
				end
				endcase
			end
		end
		// header and data results carry this step's length registers
		res.mode_val = mode_d;
		res.name_length = nlen_d;
		res.body_len = clen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= arp_pkg::PH_IDLE;
			count_q  <= 48'd0;
			hash_q   <= 8'd0;
			mode_q   <= 24'd0;
			nlen_q   <= 16'd0;
			clen_q   <= 48'd0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			hash_q   <= hash_d;
			mode_q   <= mode_d;
			nlen_q   <= nlen_d;
			clen_q   <= clen_d;
			halted_q <= halted_d;
		end
	end
endmodule

FILE: sv/arp_queue.sv
// ----------------------------------------------------------------------------
// arp_queue
// Two-entry result queue between the parser and the output register.
// ----------------------------------------------------------------------------
module arp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  arp_pkg::result_t wr_data,
	output logic             full,
	output logic             rd_valid,
	input  logic             rd_en,
	output arp_pkg::result_t rd_data
);
	arp_pkg::result_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule

FILE: sv/arp_back.sv
// ----------------------------------------------------------------------------
// arp_back
// Output register: packs queued results onto the master stream.
// ----------------------------------------------------------------------------
module arp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  arp_pkg::result_t q_data,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [111:0]     m_tdata,
	output logic [2:0]       m_tuser
);
	logic             vld_q;
	arp_pkg::result_t r_q;

	assign q_pop    = q_valid && (!vld_q || m_tready);
	assign m_tvalid = vld_q;
	assign m_tuser  = r_q.kind;
	assign m_tdata  = {5'd0, r_q.hash_value, r_q.error_code, r_q.out_byte,
		r_q.body_len, r_q.name_length, r_q.mode_val};

	always_ff @(posedge clk) begin
		if (q_pop)
			r_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (q_pop)
			vld_q <= 1'b1;
		else if (m_tready)
			vld_q <= 1'b0;
	end
endmodule

FILE: sv/archive_record_parser_pearson.sv
// Archive record parser with Pearson check. One byte is taken per cycle while
// the internal two-entry result queue has room; each byte costs one table
// lookup of the 256-entry permutation. A result is written to the queue and then
// to the output register; under back-pressure it waits behind up to one queued
// result and the stalled output. Ready drops only when the queue is full.
// ----------------------------------------------------------------------------
// archive_record_parser_pearson
// Top level: parser front, result queue and output register.
// ----------------------------------------------------------------------------
module archive_record_parser_pearson (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,      // verify_hash
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,       // data_byte
	input  logic         s_tuser,       // stream_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,       // mode, name_length, body length,
	                                    // out_byte, error_code, hash_value, pad 5
	output logic [2:0]   m_tuser        // kind
);
	logic             verify_q;
	logic             fire, rv, full, qv, pop;
	arp_pkg::result_t res, qd;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign fire      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			verify_q <= 1'b1;
		else if (cfg_valid)
			verify_q <= cfg_data;
	end

	arp_front u_front (.clk, .arst_n, .verify_hash(verify_q), .in_fire(fire),
		.data_byte(s_tdata), .stream_end(s_tuser), .res_valid(rv), .res);

	arp_queue u_queue (.clk, .arst_n, .wr_en(rv), .wr_data(res), .full,
		.rd_valid(qv), .rd_en(pop), .rd_data(qd));

	arp_back u_back (.clk, .arst_n, .q_valid(qv), .q_data(qd), .q_pop(pop),
		.m_tvalid, .m_tready, .m_tdata, .m_tuser);
endmodule

FILE: sv/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on the record parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "archive_record_parser_pearson_defines.svh"
module arp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata,
	input logic [2:0]   m_tuser
);
	`ARP_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")
	`ARP_ASSERT_NOW(a_kind, clk, arst_n, m_tvalid, m_tuser <= arp_pkg::K_DONE, "kind out of range")
	`ARP_ASSERT_NOW(a_err, clk, arst_n, m_tvalid && m_tuser != arp_pkg::K_ERROR, m_tdata[98:96] == arp_pkg::E_NONE, "error code without error")
	`ARP_ASSERT_NOW(a_byte, clk, arst_n, m_tvalid && m_tuser != arp_pkg::K_NAME && m_tuser != arp_pkg::K_CONTENT, m_tdata[95:88] == 8'd0, "stray byte")
endmodule

bind archive_record_parser_pearson arp_checker u_arp_checker (.clk, .arst_n, .m_tvalid,
	.m_tready, .m_tdata, .m_tuser);
